FILE: hw/rtl/sdl_pkg.sv
// Shared widths, constants and register codes of the smoothed drive level block.
package sdl_pkg;

  localparam int LEVEL_W    = 15;
  localparam int IN_W       = 16;
  localparam int WEIGHT_W   = 17;
  localparam int DECAY_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int WINDOW_DEF = 100;

  localparam logic [WEIGHT_W-1:0] ONE_Q16          = 17'd65536;
  localparam logic [WEIGHT_W-1:0] NOV_WEIGHT_RST   = 17'd32768;
  localparam logic [WEIGHT_W-1:0] ERR_WEIGHT_RST   = 17'd32768;
  localparam logic [DECAY_W-1:0]  DECAY_RATE_RST   = 16'd205;
  localparam logic [LEVEL_W-1:0]  MAX_LEVEL_RST    = 15'd4096;

  localparam logic signed [15:0] TENTH_Q16  = 16'sd6554;
  localparam logic signed [16:0] HALF_Q16   = 17'sd32768;
  localparam logic [8:0]         HALF_Q8    = 9'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOV_WEIGHT = 2'd0,
    CFG_ERR_WEIGHT = 2'd1,
    CFG_DECAY_RATE = 2'd2,
    CFG_MAX_LEVEL  = 2'd3
  } cfg_idx_t;

  function automatic logic [WEIGHT_W-1:0] clamp_weight(input logic [CFG_DATA_W-1:0] v);
    logic [WEIGHT_W-1:0] w;
    w = v[WEIGHT_W-1:0];
    return (w > ONE_Q16) ? ONE_Q16 : w;
  endfunction

endpackage

FILE: hw/rtl/sdl_if.sv
// Valid/ready channel interfaces for input items and result items.
interface sdl_in_if;
  import sdl_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] novelty;
  logic signed [IN_W-1:0] pred_error;
  logic signed [IN_W-1:0] time_step;

  modport source (output valid, output novelty, output pred_error, output time_step,
                  input ready);
  modport sink   (input valid, input novelty, input pred_error, input time_step,
                  output ready);
endinterface

interface sdl_out_if;
  import sdl_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level_out;
  logic [LEVEL_W-1:0] window_mean;
  logic [LEVEL_W-1:0] window_peak;
  logic               was_updated;

  modport source (output valid, output level_out, output window_mean, output window_peak,
                  output was_updated, input ready);
  modport sink   (input valid, input level_out, input window_mean, input window_peak,
                  input was_updated, output ready);
endinterface

FILE: hw/rtl/sdl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sdl_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 100
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/sdl_div.sv
// Restoring divider: one quotient bit per cycle.
module sdl_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NUM_W);
      q_r    <= num;
      den_r  <= den;
      rem_r  <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DEN_W'(trial - {1'b0, den_r});
      end else begin
        rem_r <= trial[DEN_W-1:0];
      end
      q_r   <= {q_r[NUM_W-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

FILE: hw/rtl/smoothed_drive_level_with_window_stats.sv
// An accepted item with positive time step passes the multiply, difference, step and level
// states, then the ring read and write, before the scan; an item whose step is not positive
// goes straight to the scan. The ring scan (one stored level per cycle through the RAM read
// port) and the serial mean divide run side by side; one item is in flight at a time.
// Reset: level, ring pointer, fill count and sum clear; registers return to defaults.
module smoothed_drive_level_with_window_stats #(
  parameter int WINDOW = sdl_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  sdl_in_if.sink                           in_ch,
  sdl_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [sdl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import sdl_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = LEVEL_W + CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_N, ST_MUL_E, ST_DIFF, ST_STEP, ST_LEVEL,
    ST_RING_RD, ST_RING_WR, ST_START, ST_SCAN, ST_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [WEIGHT_W-1:0] nov_w_r;
  logic [WEIGHT_W-1:0] err_w_r;
  logic [DECAY_W-1:0]  decay_r;
  logic [LEVEL_W-1:0]  max_lvl_r;

  // persistent state
  logic [LEVEL_W-1:0] level_r;
  logic [PTR_W-1:0]   wp_r;
  logic [CNT_W-1:0]   fill_r;
  logic [SUM_W-1:0]   sum_r;

  // item datapath
  logic signed [IN_W-1:0] nov_r;
  logic signed [IN_W-1:0] err_r;
  logic signed [IN_W-1:0] dt_r;
  logic signed [33:0]     prod_n_r;
  logic signed [34:0]     acc_r;
  logic signed [19:0]     diff_r;
  logic [23:0]            dec_r;
  logic signed [35:0]     stepprod_r;
  logic                   updated_r;

  // scan
  logic [CNT_W-1:0]   scan_idx_r;
  logic               pend_r;
  logic [LEVEL_W-1:0] peak_r;

  // output register
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [LEVEL_W-1:0] out_mean_r;
  logic [LEVEL_W-1:0] out_peak_r;
  logic               out_upd_r;

  logic               in_acc;
  logic               out_load;
  logic               full;
  logic               scan_done;
  logic               ram_we;
  logic [PTR_W-1:0]   ram_raddr;
  logic [LEVEL_W-1:0] ram_rdata;
  logic               div_start;
  logic               div_busy;
  logic [SUM_W-1:0]   div_quot;

  logic signed [18:0] target;
  logic [31:0]        dec_prod;
  logic signed [19:0] step;
  logic signed [26:0] lvl_sum;
  logic [LEVEL_W-1:0] lvl_nxt;

  assign in_ch.ready = rst_n && (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign full        = (fill_r == CNT_W'(WINDOW));
  assign scan_done   = (scan_idx_r >= fill_r) && !pend_r;

  assign target   = acc_r[34:16];
  assign dec_prod = 32'(decay_r) * 32'(dt_r[IN_W-2:0]) + 32'(HALF_Q8);
  assign step     = stepprod_r[35:16];
  assign lvl_sum  = 27'($signed({1'b0, level_r})) + 27'(step)
                  - 27'($signed({1'b0, dec_r}));

  always_comb begin
    if (lvl_sum < 0) begin
      lvl_nxt = '0;
    end else if (lvl_sum > 27'($signed({1'b0, max_lvl_r}))) begin
      lvl_nxt = max_lvl_r;
    end else begin
      lvl_nxt = lvl_sum[LEVEL_W-1:0];
    end
  end

  assign ram_we    = (state_r == ST_RING_WR);
  assign ram_raddr = (state_r == ST_SCAN) ? scan_idx_r[PTR_W-1:0] : wp_r;
  assign div_start = (state_r == ST_START);

  sdl_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(level_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sdl_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (sum_r),
    .den  (fill_r),
    .busy (div_busy),
    .quot (div_quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nov_w_r   <= NOV_WEIGHT_RST;
      err_w_r   <= ERR_WEIGHT_RST;
      decay_r   <= DECAY_RATE_RST;
      max_lvl_r <= MAX_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NOV_WEIGHT: nov_w_r   <= clamp_weight(cfg_wdata);
        CFG_ERR_WEIGHT: err_w_r   <= clamp_weight(cfg_wdata);
        CFG_DECAY_RATE: decay_r   <= cfg_wdata[DECAY_W-1:0];
        CFG_MAX_LEVEL:  max_lvl_r <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      pend_r      <= 1'b0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            nov_r     <= in_ch.novelty;
            err_r     <= in_ch.pred_error;
            dt_r      <= in_ch.time_step;
            updated_r <= (in_ch.time_step > 0);
            state_r   <= (in_ch.time_step > 0) ? ST_MUL_N : ST_START;
          end
        end
        ST_MUL_N: begin
          prod_n_r <= $signed({1'b0, nov_w_r}) * nov_r;
          state_r  <= ST_MUL_E;
        end
        ST_MUL_E: begin
          acc_r   <= 35'(prod_n_r) + 35'($signed({1'b0, err_w_r}) * err_r);
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          diff_r  <= 20'(target) - $signed({5'b0, level_r});
          dec_r   <= dec_prod[31:8];
          state_r <= ST_STEP;
        end
        ST_STEP: begin
          stepprod_r <= 36'(diff_r) * 36'(TENTH_Q16) + 36'(HALF_Q16);
          state_r    <= ST_LEVEL;
        end
        ST_LEVEL: begin
          level_r <= lvl_nxt;
          state_r <= ST_RING_RD;
        end
        ST_RING_RD: begin
          // fetch the entry about to be overwritten
          state_r <= ST_RING_WR;
        end
        ST_RING_WR: begin
          sum_r <= sum_r - (full ? SUM_W'(ram_rdata) : SUM_W'(0)) + SUM_W'(level_r);
          wp_r  <= (wp_r == PTR_W'(WINDOW - 1)) ? '0 : wp_r + 1'b1;
          if (!full) begin
            fill_r <= fill_r + 1'b1;
          end
          state_r <= ST_START;
        end
        ST_START: begin
          scan_idx_r <= '0;
          pend_r     <= 1'b0;
          peak_r     <= '0;
          state_r    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_idx_r < fill_r) begin
            scan_idx_r <= scan_idx_r + 1'b1;
            pend_r     <= 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r && (ram_rdata > peak_r)) begin
            peak_r <= ram_rdata;
          end
          if (scan_done && !div_busy) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_level_r <= level_r;
            out_mean_r  <= (fill_r == '0) ? '0 : div_quot[LEVEL_W-1:0];
            out_peak_r  <= peak_r;
            out_upd_r   <= updated_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.level_out   = out_level_r;
  assign out_ch.window_mean = out_mean_r;
  assign out_ch.window_peak = out_peak_r;
  assign out_ch.was_updated = out_upd_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW))
    else $error("fill count beyond window");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= PTR_W'(WINDOW - 1))
    else $error("write pointer beyond window");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside completion");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ch.ready)
    else $error("second item taken while one is in flight");

endmodule
